// File: hw/rtl/dwsc_pkg.sv
// ----------------------------------------------------------------------------
// dwsc_pkg
// Types and constants shared by the dual wheel sync corrector.
// ----------------------------------------------------------------------------
`default_nettype none

package dwsc_pkg;

    localparam int unsigned CNT_W    = 15;
    localparam int unsigned IDX_W    = 16;
    localparam int unsigned THR_W    = 24;
    localparam int unsigned PULSE_W  = 8;
    localparam int unsigned CFG_AW   = 3;
    localparam int unsigned CFG_DW   = 15;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};
    localparam logic [THR_W-1:0] THR_MAX = {THR_W{1'b1}};

    localparam logic [7:0]       RST_CHECK_GAP   = 8'd12;
    localparam logic [7:0]       RST_LEFT_LIMIT  = 8'd6;
    localparam logic [7:0]       RST_RIGHT_LIMIT = 8'd5;
    localparam logic [CNT_W-1:0] RST_WRAP_AMOUNT = 15'd30000;
    localparam logic [7:0]       RST_PULSE_TICKS = 8'd5;

    localparam logic [CFG_AW-1:0] REG_CHECK_GAP   = 3'd0;
    localparam logic [CFG_AW-1:0] REG_LEFT_LIMIT  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_RIGHT_LIMIT = 3'd2;
    localparam logic [CFG_AW-1:0] REG_WRAP_AMOUNT = 3'd3;
    localparam logic [CFG_AW-1:0] REG_PULSE_TICKS = 3'd4;

    localparam logic [1:0] SIDE_NONE  = 2'd0;
    localparam logic [1:0] SIDE_LEFT  = 2'd1;
    localparam logic [1:0] SIDE_RIGHT = 2'd2;

    typedef struct packed {
        logic [7:0]       check_gap;
        logic [7:0]       left_lead_limit;
        logic [7:0]       right_lead_limit;
        logic [CNT_W-1:0] wrap_amount;
        logic [7:0]       pulse_ticks;
    } t_cfg;

    typedef struct packed {
        logic [CNT_W-1:0]   left_count;
        logic [CNT_W-1:0]   right_count;
        logic [IDX_W-1:0]   check_index;
        logic [THR_W-1:0]   next_threshold;
        logic [PULSE_W-1:0] pulse_left;
        logic [1:0]         pulse_side;
    } t_state;

endpackage

`default_nettype wire

// File: hw/rtl/dwsc_step.sv
// ----------------------------------------------------------------------------
// dwsc_step
// Next-state and output logic for one tick of the wheel sync corrector.
// ----------------------------------------------------------------------------
`default_nettype none

module dwsc_step import dwsc_pkg::*; (
    input  wire t_state i_state,
    input  wire t_cfg   i_cfg,
    input  wire logic   i_left_edge,
    input  wire logic   i_right_edge,
    input  wire logic   i_balance_enable,
    output t_state      o_state,
    output logic        o_left_up,
    output logic        o_right_up
);

    logic [CNT_W-1:0]   lc1;
    logic [CNT_W-1:0]   rc1;
    logic [CNT_W-1:0]   lc2;
    logic [CNT_W-1:0]   rc2;
    logic [THR_W:0]     thr_sum;
    logic [PULSE_W-1:0] pulse_dec;
    logic [PULSE_W-1:0] pulse_len;
    logic               hit;
    logic               wrap;
    logic               left_lead;
    logic               right_lead;

    always_comb begin
        lc1 = (i_left_edge && (i_state.left_count != CNT_MAX)) ?
              i_state.left_count + CNT_W'(1) : i_state.left_count;
        rc1 = (i_right_edge && (i_state.right_count != CNT_MAX)) ?
              i_state.right_count + CNT_W'(1) : i_state.right_count;

        hit = ({{(THR_W-CNT_W){1'b0}}, lc1} >= i_state.next_threshold) ||
              ({{(THR_W-CNT_W){1'b0}}, rc1} >= i_state.next_threshold);

        thr_sum = {1'b0, i_state.next_threshold} + (THR_W+1)'(i_cfg.check_gap)
                  + (THR_W+1)'(1);

        wrap = (lc1 > i_cfg.wrap_amount) && (rc1 > i_cfg.wrap_amount);
        lc2  = wrap ? lc1 - i_cfg.wrap_amount : lc1;
        rc2  = wrap ? rc1 - i_cfg.wrap_amount : rc1;

        left_lead  = (lc2 > rc2) &&
                     ((lc2 - rc2) > {{(CNT_W-8){1'b0}}, i_cfg.left_lead_limit});
        right_lead = (rc2 > lc2) &&
                     ((rc2 - lc2) > {{(CNT_W-8){1'b0}}, i_cfg.right_lead_limit});

        pulse_len = (i_cfg.pulse_ticks == '0) ? PULSE_W'(1) : i_cfg.pulse_ticks;
        pulse_dec = (i_state.pulse_left != '0) ?
                    i_state.pulse_left - PULSE_W'(1) : i_state.pulse_left;

        o_state    = i_state;
        o_left_up  = 1'b0;
        o_right_up = 1'b0;
        o_state.left_count  = lc1;
        o_state.right_count = rc1;

        if (i_state.pulse_side != SIDE_NONE) begin
            o_left_up  = (i_state.pulse_side == SIDE_LEFT);
            o_right_up = (i_state.pulse_side == SIDE_RIGHT);
            o_state.pulse_left = pulse_dec;
            if (pulse_dec == '0) begin
                o_state.pulse_side = SIDE_NONE;
            end
        end else if (!i_balance_enable) begin
            o_state.left_count     = '0;
            o_state.right_count    = '0;
            o_state.check_index    = IDX_W'(1);
            o_state.next_threshold = THR_W'(i_cfg.check_gap) + THR_W'(1);
        end else if (hit) begin
            if (i_state.check_index != IDX_MAX) begin
                o_state.check_index    = i_state.check_index + IDX_W'(1);
                o_state.next_threshold = thr_sum[THR_W] ? THR_MAX : thr_sum[THR_W-1:0];
            end
            o_state.left_count  = lc2;
            o_state.right_count = rc2;
            if (left_lead || right_lead) begin
                o_right_up = left_lead;
                o_left_up  = !left_lead;
                o_state.pulse_left = pulse_len - PULSE_W'(1);
                if (pulse_len == PULSE_W'(1)) begin
                    o_state.pulse_side = SIDE_NONE;
                end else begin
                    o_state.pulse_side = left_lead ? SIDE_RIGHT : SIDE_LEFT;
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/dual_wheel_sync_corrector_core.sv
// ----------------------------------------------------------------------------
// dual_wheel_sync_corrector_core
// Counts wheel edges and issues boost pulses to the lagging wheel.
// Input transfer to result valid passes the input reg, then the result reg.
// Throughput: 1 tick item per cycle unless the output stalls.
// Reset: synchronous, active low; clears state, restores register defaults,
// empties both pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_wheel_sync_corrector_core import dwsc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_AW-1:0] i_cfg_addr,
    input  wire logic [CFG_DW-1:0] i_cfg_wdata,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_left_edge,
    input  wire logic              i_right_edge,
    input  wire logic              i_balance_enable,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic                   o_left_up,
    output logic                   o_right_up
);

    t_cfg   r_cfg;
    t_state r_state;
    t_state n_state;
    logic   r_in_valid;
    logic   r_left_edge;
    logic   r_right_edge;
    logic   r_balance_enable;
    logic   r_out_valid;
    logic   r_left_up;
    logic   r_right_up;
    logic   n_left_up;
    logic   n_right_up;
    logic   advance;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_left_up   = r_left_up;
    assign o_right_up  = r_right_up;

    dwsc_step u_step (
        .i_state          (r_state),
        .i_cfg            (r_cfg),
        .i_left_edge      (r_left_edge),
        .i_right_edge     (r_right_edge),
        .i_balance_enable (r_balance_enable),
        .o_state          (n_state),
        .o_left_up        (n_left_up),
        .o_right_up       (n_right_up)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.check_gap        <= RST_CHECK_GAP;
            r_cfg.left_lead_limit  <= RST_LEFT_LIMIT;
            r_cfg.right_lead_limit <= RST_RIGHT_LIMIT;
            r_cfg.wrap_amount      <= RST_WRAP_AMOUNT;
            r_cfg.pulse_ticks      <= RST_PULSE_TICKS;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_CHECK_GAP:   r_cfg.check_gap        <= i_cfg_wdata[7:0];
                REG_LEFT_LIMIT:  r_cfg.left_lead_limit  <= i_cfg_wdata[7:0];
                REG_RIGHT_LIMIT: r_cfg.right_lead_limit <= i_cfg_wdata[7:0];
                REG_WRAP_AMOUNT: r_cfg.wrap_amount      <= i_cfg_wdata[CNT_W-1:0];
                REG_PULSE_TICKS: r_cfg.pulse_ticks      <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.left_count     <= '0;
            r_state.right_count    <= '0;
            r_state.check_index    <= IDX_W'(1);
            r_state.next_threshold <= THR_W'(RST_CHECK_GAP) + THR_W'(1);
            r_state.pulse_left     <= '0;
            r_state.pulse_side     <= SIDE_NONE;
            r_in_valid             <= 1'b0;
            r_out_valid            <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_left_edge      <= i_left_edge;
            r_right_edge     <= i_right_edge;
            r_balance_enable <= i_balance_enable;
        end
        if (advance) begin
            r_left_up  <= n_left_up;
            r_right_up <= n_right_up;
        end
    end

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_left_up && r_right_up))
        else $error("both boost outputs active");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> $stable(r_state))
        else $error("state advanced while result stalled");

    a_pulse_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.pulse_side == SIDE_NONE) |-> (r_state.pulse_left == '0))
        else $error("pulse count left over with no pulse active");

    a_index_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.check_index != '0)
        else $error("check index reached zero");

endmodule

`default_nettype wire

// File: test/dual_wheel_sync_corrector_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_wheel_sync_corrector_core_test
// Self-checking bench for the wheel sync corrector. A queue of tick items feeds
// a valid/ready driver; every accepted tick runs through a behavioral model of
// the edge counters, the running check threshold and the boost pulse, and the
// resulting left/right boost flags are compared with each output transfer.
// Phases cover directed ticks, extreme and random register settings, and
// sender and receiver stalls.
// ----------------------------------------------------------------------------

module dual_wheel_sync_corrector_core_test;
    import dwsc_pkg::*;

    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic balance_enable;
        logic right_edge;
        logic left_edge;
    } tick_t;

    typedef struct packed {
        logic left_up;
        logic right_up;
    } boost_t;

    // {balance_enable, right_edge, left_edge}
    localparam logic [2:0] DIRECTED_TICKS [26] = '{
        3'b000, 3'b011, 3'b001, 3'b010,
        3'b101, 3'b101, 3'b101, 3'b010, 3'b010,
        3'b111, 3'b110, 3'b110, 3'b110,
        3'b111, 3'b111, 3'b111, 3'b111, 3'b111, 3'b111,
        3'b000, 3'b000, 3'b000, 3'b011,
        3'b111, 3'b111, 3'b111
    };

    logic              i_clk;
    logic              i_rst_n          = 1'b0;
    logic              i_cfg_we         = 1'b0;
    logic [CFG_AW-1:0] i_cfg_addr       = '0;
    logic [CFG_DW-1:0] i_cfg_wdata      = '0;
    logic              i_in_valid       = 1'b0;
    logic              o_in_ready;
    logic              i_left_edge      = 1'b0;
    logic              i_right_edge     = 1'b0;
    logic              i_balance_enable = 1'b0;
    logic              o_out_valid;
    logic              i_out_ready      = 1'b0;
    logic              o_left_up;
    logic              o_right_up;

    dual_wheel_sync_corrector_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_left_edge      (i_left_edge),
        .i_right_edge     (i_right_edge),
        .i_balance_enable (i_balance_enable),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_left_up        (o_left_up),
        .o_right_up       (o_right_up)
    );

    // model state
    t_cfg             wheel_cfg;
    logic [CNT_W-1:0] left_edges;
    logic [CNT_W-1:0] right_edges;
    logic [IDX_W-1:0] check_num;
    logic [THR_W-1:0] threshold;
    logic [7:0]       pulse_remaining;
    logic [1:0]       boost_side;

    tick_t  tick_q[$];
    boost_t boost_q[$];
    tick_t  driven_tick;
    int     ticks_outstanding = 0;
    int     sender_idle_pct   = 0;
    int     recv_stall_pct    = 0;
    int     mismatches        = 0;
    int     ticks_accepted    = 0;
    int     boosts_checked    = 0;
    int     left_boost_ticks  = 0;
    int     right_boost_ticks = 0;
    int     checks_run        = 0;
    int     idle_cycles       = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < 40) begin
            $display("MISMATCH at %0t, result %0d: %s", $realtime, boosts_checked, msg);
        end
        mismatches++;
    endtask

    task automatic predict_tick(input tick_t t);
        boost_t           r;
        logic [THR_W:0]   sum;
        logic [7:0]       len;
        logic             start;
        r = '0;
        start = 1'b0;
        if (t.left_edge && left_edges != CNT_MAX) left_edges++;
        if (t.right_edge && right_edges != CNT_MAX) right_edges++;
        if (boost_side != SIDE_NONE) begin
            r.left_up  = (boost_side == SIDE_LEFT);
            r.right_up = (boost_side == SIDE_RIGHT);
            if (pulse_remaining != '0) pulse_remaining--;
            if (pulse_remaining == '0) boost_side = SIDE_NONE;
        end else if (!t.balance_enable) begin
            left_edges  = '0;
            right_edges = '0;
            check_num   = IDX_W'(1);
            threshold   = THR_W'(wheel_cfg.check_gap) + THR_W'(1);
        end else if (left_edges >= threshold || right_edges >= threshold) begin
            checks_run++;
            if (check_num != IDX_MAX) begin
                check_num++;
                sum = {1'b0, threshold} + (THR_W+1)'(wheel_cfg.check_gap)
                      + (THR_W+1)'(1);
                threshold = (sum > THR_MAX) ? THR_MAX : sum[THR_W-1:0];
            end
            if (left_edges > wheel_cfg.wrap_amount && right_edges > wheel_cfg.wrap_amount) begin
                left_edges  = left_edges - wheel_cfg.wrap_amount;
                right_edges = right_edges - wheel_cfg.wrap_amount;
            end
            len = (wheel_cfg.pulse_ticks == '0) ? 8'd1 : wheel_cfg.pulse_ticks;
            if (left_edges > right_edges
                && left_edges - right_edges > wheel_cfg.left_lead_limit) begin
                boost_side = SIDE_RIGHT;
                r.right_up = 1'b1;
                start = 1'b1;
            end else if (right_edges > left_edges
                && right_edges - left_edges > wheel_cfg.right_lead_limit) begin
                boost_side = SIDE_LEFT;
                r.left_up = 1'b1;
                start = 1'b1;
            end
            if (start) begin
                pulse_remaining = len - 8'd1;
                if (pulse_remaining == '0) boost_side = SIDE_NONE;
            end
        end
        if (r.left_up) left_boost_ticks++;
        if (r.right_up) right_boost_ticks++;
        boost_q.push_back(r);
    endtask

    task automatic push_tick(input tick_t t);
        tick_q.push_back(t);
        ticks_outstanding++;
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        case (addr)
            REG_CHECK_GAP:   wheel_cfg.check_gap        = value[7:0];
            REG_LEFT_LIMIT:  wheel_cfg.left_lead_limit  = value[7:0];
            REG_RIGHT_LIMIT: wheel_cfg.right_lead_limit = value[7:0];
            REG_WRAP_AMOUNT: wheel_cfg.wrap_amount      = value[CNT_W-1:0];
            REG_PULSE_TICKS: wheel_cfg.pulse_ticks      = value[7:0];
            default: ;
        endcase
    endtask

    task automatic configure(input int gap, input int left_lim, input int right_lim,
                             input int wrap, input int pulse);
        write_reg(REG_CHECK_GAP, CFG_DW'(gap));
        write_reg(REG_LEFT_LIMIT, CFG_DW'(left_lim));
        write_reg(REG_RIGHT_LIMIT, CFG_DW'(right_lim));
        write_reg(REG_WRAP_AMOUNT, CFG_DW'(wrap));
        write_reg(REG_PULSE_TICKS, CFG_DW'(pulse));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait for every tick and every boost result to drain, then let the pipe settle
    task automatic settle();
        while (ticks_outstanding != 0 || boost_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // mostly enabled segments with a biased edge mix so one wheel leads;
    // some segments are pure noise
    task automatic queue_random(input int n);
        int    seg_left;
        int    p_left;
        int    p_right;
        bit    noise;
        tick_t t;
        seg_left = 0;
        p_left   = 0;
        p_right  = 0;
        noise    = 1'b0;
        for (int i = 0; i < n; i++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(10, 80);
                p_left   = $urandom_range(0, 100);
                p_right  = $urandom_range(0, 100);
                case ($urandom_range(0, 3))
                    0: p_left  = 100;
                    1: p_right = 100;
                    default: ;
                endcase
                noise = ($urandom_range(0, 9) == 0);
            end
            seg_left--;
            if (noise) begin
                t = tick_t'(3'($urandom_range(0, 7)));
            end else begin
                t.left_edge      = ($urandom_range(0, 99) < p_left);
                t.right_edge     = ($urandom_range(0, 99) < p_right);
                t.balance_enable = ($urandom_range(0, 99) >= 2);
            end
            push_tick(t);
        end
    endtask

    always @(posedge i_clk) begin : drive_ticks
        logic fired;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            fired = i_in_valid && o_in_ready;
            if (fired) begin
                predict_tick(driven_tick);
                ticks_outstanding--;
                ticks_accepted++;
            end
            if (!i_in_valid || fired) begin
                if (tick_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    driven_tick = tick_q.pop_front();
                    i_in_valid       <= 1'b1;
                    i_left_edge      <= driven_tick.left_edge;
                    i_right_edge     <= driven_tick.right_edge;
                    i_balance_enable <= driven_tick.balance_enable;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_boosts
        boost_t want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (boost_q.size() == 0) begin
                    report_mismatch("result transfer with no tick pending");
                end else begin
                    want = boost_q.pop_front();
                    if (o_left_up !== want.left_up) begin
                        report_mismatch($sformatf("left_up expected %0b got %0b",
                                                  want.left_up, o_left_up));
                    end
                    if (o_right_up !== want.right_up) begin
                        report_mismatch($sformatf("right_up expected %0b got %0b",
                                                  want.right_up, o_right_up));
                    end
                end
                boosts_checked++;
            end
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d ticks and %0d results pending",
                     idle_cycles, ticks_outstanding, boost_q.size());
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : run_test
        wheel_cfg.check_gap        = RST_CHECK_GAP;
        wheel_cfg.left_lead_limit  = RST_LEFT_LIMIT;
        wheel_cfg.right_lead_limit = RST_RIGHT_LIMIT;
        wheel_cfg.wrap_amount      = RST_WRAP_AMOUNT;
        wheel_cfg.pulse_ticks      = RST_PULSE_TICKS;
        left_edges      = '0;
        right_edges     = '0;
        check_num       = IDX_W'(1);
        threshold       = THR_W'(RST_CHECK_GAP) + THR_W'(1);
        pulse_remaining = '0;
        boost_side      = SIDE_NONE;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: clears, pulse on each side, enable low during a pulse, wrap
        configure(2, 1, 0, 3, 3);
        foreach (DIRECTED_TICKS[i]) push_tick(tick_t'(DIRECTED_TICKS[i]));
        settle();

        // low extremes: a check gap of zero, one-tick pulses (zero length)
        configure(0, 0, 0, 1, 0);
        queue_random(300);
        settle();

        // high extremes, sparse sender
        sender_idle_pct = 85;
        configure(255, 255, 255, 32767, 255);
        queue_random(300);
        settle();

        // zero wrap, stalling receiver
        sender_idle_pct = 0;
        recv_stall_pct  = 85;
        configure(5, 3, 2, 0, 4);
        queue_random(400);
        settle();

        // random settings, both sides idle now and then
        sender_idle_pct = 17;
        recv_stall_pct  = 17;
        configure($urandom_range(0, 15), $urandom_range(0, 10), $urandom_range(0, 10),
                  $urandom_range(1, 100), $urandom_range(0, 8));
        queue_random(600);
        settle();

        $display("Covered %0d ticks and %0d results over five register settings",
                 ticks_accepted, boosts_checked);
        $display("%0d checks, %0d left boost ticks, %0d right boost ticks, %0d mismatches",
                 checks_run, left_boost_ticks, right_boost_ticks, mismatches);
        if (mismatches == 0 && boost_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
